>>> rtl/vng_pkg.sv
`timescale 1ns / 1ps

package vng_pkg;

    // Field widths
    localparam int IDX_W      = 30;
    localparam int CFG_SIZE_W = 11;
    localparam int CFG_WRAP_W = 3;
    localparam int OUT_W      = 2;
    localparam int NUM_DIRS   = 6;
    localparam int DIR_W      = 3;

    // Result outcome codes
    localparam logic [OUT_W-1:0] OUT_NEIGHBOR = 2'd0;
    localparam logic [OUT_W-1:0] OUT_NONE     = 2'd1;
    localparam logic [OUT_W-1:0] OUT_RANGE    = 2'd2;

    // Register indexes (byte address / 4)
    localparam logic [1:0] REG_SIZE_X = 2'd0;
    localparam logic [1:0] REG_SIZE_Y = 2'd1;
    localparam logic [1:0] REG_SIZE_Z = 2'd2;
    localparam logic [1:0] REG_WRAP   = 2'd3;

    // Axis codes
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    // Per-item control handed from the divider chain to the emitter.
    // mask bit order: -x, +x, -y, +y, -z, +z
    typedef struct packed {
        logic                err;
        logic [NUM_DIRS-1:0] mask;
        logic [2:0]          lo;
        logic [2:0]          hi;
    } vng_ctl_t;

endpackage

>>> rtl/vng_div_cell.sv
`timescale 1ns / 1ps

// One restoring-division step: shift one dividend bit into the partial
// remainder, subtract the divisor if it fits, shift the quotient bit in.
module vng_div_cell
    import vng_pkg::*;
#(
    parameter int NB = 30,
    parameter int DW = 11,
    parameter int PW = 30
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          adv,
    input  logic          in_valid,
    input  logic [DW-1:0] in_r,
    input  logic [NB-1:0] in_dq,
    input  logic [PW-1:0] in_pl,
    input  logic [DW-1:0] divisor,
    output logic          out_valid,
    output logic [DW-1:0] out_r,
    output logic [NB-1:0] out_dq,
    output logic [PW-1:0] out_pl
);

    logic          valid_reg;
    logic [DW-1:0] r_reg, r_next;
    logic [NB-1:0] dq_reg, dq_next;
    logic [PW-1:0] pl_reg;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          fits;

    // one step
    always_comb begin
        trial   = {in_r, in_dq[NB-1]};
        diff    = trial - {1'b0, divisor};
        fits    = (trial >= {1'b0, divisor});
        r_next  = fits ? diff[DW-1:0] : trial[DW-1:0];
        dq_next = {in_dq[NB-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            r_reg  <= r_next;
            dq_reg <= dq_next;
            pl_reg <= in_pl;
        end
    end

    assign out_valid = valid_reg;
    assign out_r     = r_reg;
    assign out_dq    = dq_reg;
    assign out_pl    = pl_reg;

endmodule

>>> rtl/vng_emit.sv
`timescale 1ns / 1ps

// Holds one decoded voxel and sends its results one per cycle, while the
// output is not stalled, through an output register.
module vng_emit
    import vng_pkg::*;
#(
    parameter int AW = 33
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             ld_valid,
    output logic             ld_ready,
    input  logic [IDX_W-1:0] ld_idx,
    input  vng_ctl_t         ld_ctl,
    input  logic [AW-1:0]    k_sx,
    input  logic [AW-1:0]    k_sxy,
    input  logic [AW-1:0]    k_xwrap,
    input  logic [AW-1:0]    k_ywrap,
    input  logic [AW-1:0]    k_zwrap,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_outcome,
    output logic [IDX_W-1:0] m_nidx,
    output logic             m_final
);

    logic                busy_reg;
    logic [NUM_DIRS-1:0] mask_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [2:0]          lo_reg;
    logic [2:0]          hi_reg;
    logic [OUT_W-1:0]    kind_reg;

    logic                tvalid_reg;
    logic [OUT_W-1:0]    outcome_reg;
    logic [IDX_W-1:0]    nidx_reg;
    logic                final_reg;

    logic [NUM_DIRS-1:0] pick;
    logic [DIR_W-1:0]    dir;
    logic [1:0]          axis;
    logic                plus;
    logic                at_edge;
    logic                do_add;
    logic [AW-1:0]       step;
    logic [AW-1:0]       wrap;
    logic [AW-1:0]       opnd;
    logic [AW-1:0]       sum;
    logic                last_nb;
    logic                emit_last;
    logic                out_load;

    // lowest pending direction
    always_comb begin
        pick = '0;
        dir  = '0;
        for (int i = NUM_DIRS - 1; i >= 0; i--) begin
            if (mask_reg[i]) begin
                pick = NUM_DIRS'(1) << i;
                dir  = DIR_W'(i);
            end
        end
    end

    // neighbor index as center plus or minus a per-axis stride, or a wrap offset at the edge
    always_comb begin
        axis = dir[2:1];
        plus = dir[0];
        unique case (axis)
            AXIS_X: begin
                step    = AW'(1);
                wrap    = k_xwrap;
                at_edge = plus ? hi_reg[0] : lo_reg[0];
            end
            AXIS_Y: begin
                step    = k_sx;
                wrap    = k_ywrap;
                at_edge = plus ? hi_reg[1] : lo_reg[1];
            end
            AXIS_Z: begin
                step    = k_sxy;
                wrap    = k_zwrap;
                at_edge = plus ? hi_reg[2] : lo_reg[2];
            end
            default: begin
                step    = '0;
                wrap    = '0;
                at_edge = 1'b0;
            end
        endcase
        opnd   = at_edge ? wrap : step;
        do_add = plus ? !at_edge : at_edge;
        sum    = do_add ? (AW'(idx_reg) + opnd) : (AW'(idx_reg) - opnd);
    end

    assign last_nb   = ((mask_reg & ~pick) == '0);
    assign emit_last = (kind_reg != OUT_NEIGHBOR) || last_nb;
    assign out_load  = busy_reg && (!tvalid_reg || m_tready);
    assign ld_ready  = !busy_reg || (out_load && emit_last);

    // item state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (ld_valid && ld_ready) begin
            busy_reg <= 1'b1;
        end else if (out_load && emit_last) begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld_valid && ld_ready) begin
            idx_reg  <= ld_idx;
            lo_reg   <= ld_ctl.lo;
            hi_reg   <= ld_ctl.hi;
            mask_reg <= ld_ctl.err ? '0 : ld_ctl.mask;
            if (ld_ctl.err) begin
                kind_reg <= OUT_RANGE;
            end else if (ld_ctl.mask == '0) begin
                kind_reg <= OUT_NONE;
            end else begin
                kind_reg <= OUT_NEIGHBOR;
            end
        end else if (out_load) begin
            mask_reg <= mask_reg & ~pick;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tvalid_reg <= 1'b0;
        end else if (out_load) begin
            tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            outcome_reg <= kind_reg;
            nidx_reg    <= (kind_reg == OUT_NEIGHBOR) ? sum[IDX_W-1:0] : '0;
            final_reg   <= emit_last;
        end
    end

    assign m_tvalid  = tvalid_reg;
    assign m_outcome = outcome_reg;
    assign m_nidx    = nidx_reg;
    assign m_final   = final_reg;

endmodule

>>> rtl/voxel_neighbor_generate.sv
`timescale 1ns / 1ps

// Six-connected neighbor generator. Each input item is a linear voxel index;
// a chain of 2*30 one-bit divider cells splits it into x, y and z (one cell
// step per cycle and a new item every cycle, unless the emitter holds back
// the last cell), and an emitter then sends the face neighbors in the order
// -x, +x, -y, +y, -z, +z, one result per cycle while m_tready is high, with
// tlast on the last one. An item gives 1 to 6 results, which sets the
// sustained rate. Periodic axes wrap, others drop neighbors at the edge; an
// index outside the grid gives one range-error result, a voxel without
// neighbors one "none" result. The outcome code travels on m_tuser.
// Registers: 0x0 size_x, 0x4 size_y, 0x8 size_z, 0xC wrap_mask; write them
// only while no item is in flight.
module voxel_neighbor_generate
    import vng_pkg::*;
#(
    parameter int AXIS_BITS = 10
) (
    input  logic        aclk,
    input  logic        aresetn,
    // s_tdata: center_index[29:0], zero pad [31:30]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,
    // m_tdata: neighbor_index[29:0], zero pad [31:30]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,
    // m_tuser: outcome[1:0]
    output logic [1:0]  m_tuser,
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int SW  = AXIS_BITS + 1;
    localparam int CW  = (SW > CFG_SIZE_W) ? SW : CFG_SIZE_W;
    localparam int PXY = 2 * SW;
    localparam int PT  = 3 * SW;
    localparam int AW  = (PT > IDX_W) ? PT : IDX_W;
    localparam int PWB = IDX_W + SW;

    logic [CFG_SIZE_W-1:0] size_x_reg, size_y_reg, size_z_reg;
    logic [CFG_WRAP_W-1:0] wrap_reg;
    logic [SW-1:0]         sx, sy, sz;
    logic [PXY-1:0]        sxy_reg;
    logic [PT-1:0]         tot_reg;
    logic                  cfg_wr;
    logic                  adv;

    logic                  a_valid [0:IDX_W];
    logic [SW-1:0]         a_r     [0:IDX_W];
    logic [IDX_W-1:0]      a_dq    [0:IDX_W];
    logic [IDX_W-1:0]      a_pl    [0:IDX_W];
    logic                  b_valid [0:IDX_W];
    logic [SW-1:0]         b_r     [0:IDX_W];
    logic [IDX_W-1:0]      b_dq    [0:IDX_W];
    logic [PWB-1:0]        b_pl    [0:IDX_W];

    logic [IDX_W-1:0]      c_idx;
    logic [SW-1:0]         c_x, c_y;
    logic [IDX_W-1:0]      c_z;
    logic [2:0]            one_ax, two_ax;
    vng_ctl_t              ctl;
    logic                  ld_ready;
    logic [OUT_W-1:0]      e_outcome;
    logic [IDX_W-1:0]      e_nidx;

    function automatic logic [SW-1:0] clamp_size(input logic [CFG_SIZE_W-1:0] raw);
        logic [CW-1:0] r;
        logic [CW-1:0] top_v;
        r     = CW'(raw);
        top_v = CW'(1) << AXIS_BITS;
        if (raw == '0) begin
            return SW'(1);
        end else if (r > top_v) begin
            return SW'(top_v);
        end
        return SW'(r);
    endfunction

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_x_reg <= CFG_SIZE_W'(16);
            size_y_reg <= CFG_SIZE_W'(16);
            size_z_reg <= CFG_SIZE_W'(16);
            wrap_reg   <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_SIZE_X: size_x_reg <= pwdata[CFG_SIZE_W-1:0];
                REG_SIZE_Y: size_y_reg <= pwdata[CFG_SIZE_W-1:0];
                REG_SIZE_Z: size_z_reg <= pwdata[CFG_SIZE_W-1:0];
                REG_WRAP:   wrap_reg   <= pwdata[CFG_WRAP_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_SIZE_X: prdata = 32'(size_x_reg);
            REG_SIZE_Y: prdata = 32'(size_y_reg);
            REG_SIZE_Z: prdata = 32'(size_z_reg);
            REG_WRAP:   prdata = 32'(wrap_reg);
            default:    prdata = '0;
        endcase
    end

    // effective sizes and grid strides
    assign sx = clamp_size(size_x_reg);
    assign sy = clamp_size(size_y_reg);
    assign sz = clamp_size(size_z_reg);

    always_ff @(posedge aclk) begin
        sxy_reg <= PXY'(sx) * PXY'(sy);
        tot_reg <= PT'(sxy_reg) * PT'(sz);
    end

    // pipeline advances unless the last cell holds an item the emitter refuses
    assign adv      = !b_valid[IDX_W] || ld_ready;
    assign s_tready = adv;

    // first chain: index / sx
    assign a_valid[0] = s_tvalid;
    assign a_r[0]     = '0;
    assign a_dq[0]    = s_tdata[IDX_W-1:0];
    assign a_pl[0]    = s_tdata[IDX_W-1:0];

    for (genvar i = 0; i < IDX_W; i++) begin : g_div_x
        vng_div_cell #(.NB(IDX_W), .DW(SW), .PW(IDX_W)) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .adv      (adv),
            .in_valid (a_valid[i]),
            .in_r     (a_r[i]),
            .in_dq    (a_dq[i]),
            .in_pl    (a_pl[i]),
            .divisor  (sx),
            .out_valid(a_valid[i+1]),
            .out_r    (a_r[i+1]),
            .out_dq   (a_dq[i+1]),
            .out_pl   (a_pl[i+1])
        );
    end

    // second chain: (index / sx) / sy
    assign b_valid[0] = a_valid[IDX_W];
    assign b_r[0]     = '0;
    assign b_dq[0]    = a_dq[IDX_W];
    assign b_pl[0]    = {a_pl[IDX_W], a_r[IDX_W]};

    for (genvar i = 0; i < IDX_W; i++) begin : g_div_y
        vng_div_cell #(.NB(IDX_W), .DW(SW), .PW(PWB)) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .adv      (adv),
            .in_valid (b_valid[i]),
            .in_r     (b_r[i]),
            .in_dq    (b_dq[i]),
            .in_pl    (b_pl[i]),
            .divisor  (sy),
            .out_valid(b_valid[i+1]),
            .out_r    (b_r[i+1]),
            .out_dq   (b_dq[i+1]),
            .out_pl   (b_pl[i+1])
        );
    end

    // edge flags and candidate mask
    assign c_x   = b_pl[IDX_W][SW-1:0];
    assign c_idx = b_pl[IDX_W][PWB-1:SW];
    assign c_y   = b_r[IDX_W];
    assign c_z   = b_dq[IDX_W];

    always_comb begin
        ctl.err   = (AW'(c_idx) >= AW'(tot_reg));
        ctl.lo[0] = (c_x == '0);
        ctl.hi[0] = (c_x == (sx - SW'(1)));
        ctl.lo[1] = (c_y == '0);
        ctl.hi[1] = (c_y == (sy - SW'(1)));
        ctl.lo[2] = (c_z == '0);
        ctl.hi[2] = (c_z == (IDX_W'(sz) - IDX_W'(1)));
        one_ax    = {sz == SW'(1), sy == SW'(1), sx == SW'(1)};
        two_ax    = {sz == SW'(2), sy == SW'(2), sx == SW'(2)};
        for (int a = 0; a < 3; a++) begin
            ctl.mask[2*a]   = !one_ax[a] && (!ctl.lo[a] || wrap_reg[a]);
            ctl.mask[2*a+1] = !one_ax[a] && (!ctl.hi[a] || wrap_reg[a])
                              && !(wrap_reg[a] && two_ax[a]);
        end
    end

    vng_emit #(.AW(AW)) u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ld_valid (b_valid[IDX_W]),
        .ld_ready (ld_ready),
        .ld_idx   (c_idx),
        .ld_ctl   (ctl),
        .k_sx     (AW'(sx)),
        .k_sxy    (AW'(sxy_reg)),
        .k_xwrap  (AW'(sx) - AW'(1)),
        .k_ywrap  (AW'(sxy_reg) - AW'(sx)),
        .k_zwrap  (AW'(tot_reg) - AW'(sxy_reg)),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_outcome(e_outcome),
        .m_nidx   (e_nidx),
        .m_final  (m_tlast)
    );

    assign m_tdata = {2'b00, e_nidx};
    assign m_tuser = e_outcome;

endmodule

>>> rtl/vng_chk.sv
`timescale 1ns / 1ps

// Port-level checks for the neighbor generator.
module vng_chk
    import vng_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("result changed while stalled");

    // only defined outcome codes
    a_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == OUT_NEIGHBOR || m_tuser == OUT_NONE
                      || m_tuser == OUT_RANGE))
        else $error("bad outcome code");

    // error and none results are last, with zero index
    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != OUT_NEIGHBOR |-> m_tlast && m_tdata == '0)
        else $error("special result malformed");

    // no result straight out of reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind voxel_neighbor_generate vng_chk u_vng_chk (.*);
